FILE: rtl/m3ema_pkg.sv
// Shared constants and types for the median-of-three EMA smoother.
// Used by m3ema_core and median3_ema_smoother_top; depends on nothing else.
package m3ema_pkg;

    // Default sample width and alpha fraction bits.
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    // The EMA accumulator always carries this many fraction bits.
    localparam int EMA_FRAC_BITS = 16;

    // Width of the smoothing_alpha configuration register and its reset value.
    localparam int                     ALPHA_REG_WIDTH = 16;
    localparam logic [ALPHA_REG_WIDTH-1:0] ALPHA_RESET = 16'd6554;

    // Width of the kind field carried in tuser.
    localparam int KIND_WIDTH = 2;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_SAMPLE     = 2'd0,
        KIND_FORCE      = 2'd1,
        KIND_INVALIDATE = 2'd2
    } t_kind;

endpackage

FILE: rtl/m3ema_core.sv
// Filter state and combinational datapath: median of three, EMA update, rounding.
// Depends on m3ema_pkg.
module m3ema_core #(
    parameter int SAMPLE_WIDTH    = m3ema_pkg::SAMPLE_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = m3ema_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_fire,
    input  logic [m3ema_pkg::KIND_WIDTH-1:0]        i_kind,
    input  logic [SAMPLE_WIDTH-1:0]                 i_sample,
    input  logic [m3ema_pkg::ALPHA_REG_WIDTH-1:0]   i_alpha,
    output logic                                    o_has_result,
    output logic [SAMPLE_WIDTH-1:0]                 o_result
);

    localparam int EF = m3ema_pkg::EMA_FRAC_BITS;
    localparam int SW = SAMPLE_WIDTH;
    localparam int AF = ALPHA_FRAC_BITS;
    localparam int EW = SW + EF;        // accumulator width
    localparam int DW = EW + 1;         // difference width
    localparam int RW = AF + DW + 1;    // product width
    localparam int AW = (AF > m3ema_pkg::ALPHA_REG_WIDTH) ? AF : m3ema_pkg::ALPHA_REG_WIDTH;

    localparam longint unsigned AMIN = (64'd1 << AF) / 100;
    localparam longint unsigned AMAX = (64'd99 << AF) / 100;
    localparam logic [AW-1:0] ALPHA_MIN = AW'(AMIN);
    localparam logic [AW-1:0] ALPHA_MAX = AW'(AMAX);
    localparam logic signed [RW-1:0] ROUND_STEP = RW'(1) << (AF - 1);
    localparam logic signed [EW:0]   ROUND_OUT  = (EW + 1)'(1) << (EF - 1);
    localparam logic signed [SW:0]   SMAX = (SW + 1)'((1 << (SW - 1)) - 1);
    localparam logic signed [SW:0]   SMIN = -SMAX - (SW + 1)'(1);

    typedef m3ema_pkg::t_kind t_kind_local_e;

    logic                  r_primed;
    logic signed [SW-1:0]  r_hist_old;
    logic signed [SW-1:0]  r_hist_new;
    logic signed [EW-1:0]  r_ema;

    logic signed [SW-1:0]  w_x;
    logic signed [SW-1:0]  w_min_ab;
    logic signed [SW-1:0]  w_max_ab;
    logic signed [SW-1:0]  w_min_c;
    logic signed [SW-1:0]  w_med;
    logic [AW-1:0]         w_alpha_ext;
    logic [AF-1:0]         w_alpha;
    logic signed [DW-1:0]  w_diff;
    logic signed [RW-1:0]  w_prod;
    logic signed [RW-1:0]  w_rnd;
    logic signed [DW-1:0]  w_step;
    logic signed [DW-1:0]  w_sum;
    logic signed [EW-1:0]  n_ema;
    logic signed [EW:0]    w_out_rnd;
    logic signed [SW:0]    w_y_full;
    logic signed [SW-1:0]  w_y;
    t_kind_local_e         w_kind;

    assign w_kind = m3ema_pkg::t_kind'(i_kind);
    assign w_x    = $signed(i_sample);

    // Median of the two stored samples and the new one.
    assign w_min_ab = (r_hist_old < r_hist_new) ? r_hist_old : r_hist_new;
    assign w_max_ab = (r_hist_old > r_hist_new) ? r_hist_old : r_hist_new;
    assign w_min_c  = (w_max_ab < w_x) ? w_max_ab : w_x;
    assign w_med    = (w_min_ab > w_min_c) ? w_min_ab : w_min_c;

    // Alpha clamped to the 0.01 .. 0.99 range.
    assign w_alpha_ext = AW'(i_alpha);
    always_comb begin
        if (w_alpha_ext < ALPHA_MIN) begin
            w_alpha = AF'(ALPHA_MIN);
        end else if (w_alpha_ext > ALPHA_MAX) begin
            w_alpha = AF'(ALPHA_MAX);
        end else begin
            w_alpha = AF'(w_alpha_ext);
        end
    end

    // EMA step, rounded half up, then the arithmetic floor by the alpha fraction.
    assign w_diff = $signed({w_med[SW-1], w_med, {EF{1'b0}}}) - $signed({r_ema[EW-1], r_ema});
    assign w_prod = RW'($signed({1'b0, w_alpha})) * RW'(w_diff);
    assign w_rnd  = w_prod + ROUND_STEP;
    assign w_step = $signed(w_rnd[AF+DW-1:AF]);
    assign w_sum  = $signed({r_ema[EW-1], r_ema}) + w_step;
    assign n_ema  = w_sum[EW-1:0];

    // Output rounding to the nearest sample unit, with a saturation guard.
    assign w_out_rnd = $signed({n_ema[EW-1], n_ema}) + ROUND_OUT;
    assign w_y_full  = $signed(w_out_rnd[EW:EF]);
    always_comb begin
        if (w_y_full > SMAX) begin
            w_y = SMAX[SW-1:0];
        end else if (w_y_full < SMIN) begin
            w_y = SMIN[SW-1:0];
        end else begin
            w_y = w_y_full[SW-1:0];
        end
    end

    assign o_has_result = (w_kind == m3ema_pkg::KIND_SAMPLE);
    assign o_result     = r_primed ? w_y : w_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (i_fire) begin
            case (w_kind)
                m3ema_pkg::KIND_SAMPLE: begin
                    r_primed <= 1'b1;
                end
                m3ema_pkg::KIND_FORCE: begin
                    r_primed <= 1'b1;
                end
                m3ema_pkg::KIND_INVALIDATE: begin
                    r_primed <= 1'b0;
                end
                default: begin
                    r_primed <= r_primed;
                end
            endcase
        end
    end

    // History and accumulator are only read once primed, and priming loads them.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if ((w_kind == m3ema_pkg::KIND_FORCE) ||
                ((w_kind == m3ema_pkg::KIND_SAMPLE) && !r_primed)) begin
                r_hist_old <= w_x;
                r_hist_new <= w_x;
                r_ema      <= {w_x, {EF{1'b0}}};
            end else if (w_kind == m3ema_pkg::KIND_SAMPLE) begin
                r_hist_old <= r_hist_new;
                r_hist_new <= w_x;
                r_ema      <= n_ema;
            end
        end
    end

endmodule

FILE: rtl/median3_ema_smoother_top.sv
// An accepted word sits in the input register, feeding the filter datapath with no
// stage in between; the result of a sample word goes to the output register.
// Throughput: one word per cycle while no sample result waits on the sink, as force
// and invalidate words make no output word; the EMA multiply-add is combinational.
// Reset (i_rst_n low, synchronous) clears both valid flags and the primed flag and
// loads smoothing_alpha with 6554; no clearing pass is needed.
module median3_ema_smoother_top #(
    parameter int SAMPLE_WIDTH    = m3ema_pkg::SAMPLE_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = m3ema_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream.
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // tdata: sample_value in the low SAMPLE_WIDTH bits, zero padding above.
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    // tuser: kind in bits [1:0].
    input  logic [m3ema_pkg::KIND_WIDTH-1:0]       i_s_axis_tuser,
    // Output stream.
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // tdata: filtered_value in the low SAMPLE_WIDTH bits, zero padding above.
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      o_m_axis_tdata,
    // Configuration write channel for smoothing_alpha.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [m3ema_pkg::ALPHA_REG_WIDTH-1:0]  i_cfg_data
);

    localparam int TW = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // Input register: holds one accepted word until the datapath consumes it.
    logic                                  r_in_valid;
    logic [m3ema_pkg::KIND_WIDTH-1:0]      r_in_kind;
    logic [SAMPLE_WIDTH-1:0]               r_in_sample;

    // Output register: holds one result word until the sink takes it.
    logic                                  r_out_valid;
    logic [SAMPLE_WIDTH-1:0]               r_out_data;

    logic [m3ema_pkg::ALPHA_REG_WIDTH-1:0] r_alpha;

    logic                                  w_has_result;
    logic [SAMPLE_WIDTH-1:0]               w_result;
    logic                                  w_out_free;
    logic                                  w_advance;
    logic                                  w_in_fire;

    // The output register is free if empty or being drained this cycle.
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    // The held word moves on when it makes no result or the result has room.
    assign w_advance  = r_in_valid && (!w_has_result || w_out_free);
    // A new word enters when the input register is empty or being vacated.
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TW'(r_out_data);

    m3ema_core #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_advance),
        .i_kind       (r_in_kind),
        .i_sample     (r_in_sample),
        .i_alpha      (r_alpha),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_kind   <= i_s_axis_tuser;
            r_in_sample <= i_s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_has_result) begin
            r_out_data <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= m3ema_pkg::ALPHA_RESET;
        end else if (i_cfg_valid) begin
            r_alpha <= i_cfg_data;
        end
    end

`ifndef SYNTHESIS
    // A held word that cannot move on must still be held in the next cycle.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("input word lost while stalled");

    // Only sample words produce a result.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_has_result) |-> (r_in_kind == m3ema_pkg::KIND_SAMPLE))
        else $error("result produced for a non-sample word");

    // A result is never written over one that the sink has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_has_result) |-> (!r_out_valid || i_m_axis_tready))
        else $error("output word overwritten");

    // A produced result shows up on the output in the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_has_result) |=> o_m_axis_tvalid)
        else $error("produced result not presented");
`endif

endmodule
